### hdl/assert_macros.svh
// Assertion macros shared by the solver RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### hdl/lcs_pkg.sv
// Package for the linear congruence solver: payload structs, sizes, divider control.
// Depends on nothing.
`default_nettype none
package lcs_pkg;
  localparam int QUOT_DEPTH    = 64;
  localparam int MAX_SOLUTIONS = 64;
  localparam int QA_W = $clog2(QUOT_DEPTH);
  localparam int QC_W = $clog2(QUOT_DEPTH + 1);

  typedef struct packed {
    logic [30:0] coef_a;
    logic [30:0] rhs_b;
    logic [30:0] modulus;
  } lcs_in_t;

  typedef struct packed {
    logic        solvable;
    logic [30:0] solution;
    logic [5:0]  sol_index;
    logic [30:0] step;
    logic [30:0] sol_count;
    logic        truncated;
    logic        last;
  } lcs_out_t;

  // Divider request: 62-bit dividend by 31-bit divisor.
  typedef struct packed {
    logic        start;
    logic [61:0] dividend;
    logic [30:0] divisor;
  } lcs_div_req_t;

  typedef struct packed {
    logic        done;
    logic [61:0] quot;
    logic [30:0] rem;
  } lcs_div_rsp_t;
endpackage
`default_nettype wire

### hdl/lcs_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on lcs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module lcs_div import lcs_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  lcs_div_req_t req,
  output lcs_div_rsp_t rsp
);
  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [61:0] q_r, q_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [30:0] d_r, d_nxt;
  logic        done_r, done_nxt;
  logic [31:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    done_nxt = 1'b0;
    trial    = {rem_r[30:0], q_r[61]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd0;
      q_nxt    = req.dividend;
      rem_nxt  = 32'd0;
      d_nxt    = req.divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt   = {q_r[60:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[60:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd61) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r[30:0];

  `ASSERT_IMPL(a_done_after_busy, clk, rst_n, rsp.done, !busy_r)
  `ASSERT_IMPL(a_rem_below_div, clk, rst_n, rsp.done, rem_r < {1'b0, d_r})
  `ASSERT_IMPL(a_start_when_idle, clk, rst_n, req.start, !busy_r)
endmodule
`default_nettype wire

### hdl/linear_congruence_solver.sv
// Top level of the linear congruence solver: sequencer, quotient store, emitter.
// Depends on lcs_pkg, lcs_div and assert_macros.svh.
//
//   channel | direction | payload   | flow
//   in_     | input     | lcs_in_t  | valid / stall
//   out_    | output    | lcs_out_t | valid / stall
//
// One item at a time; every division runs in the shared serial divider.
// Synchronous active-low reset returns the sequencer to idle; the quotient store
// is not cleared. Output stall holds the result register and the sequencer.
`default_nettype none
`include "assert_macros.svh"
module linear_congruence_solver import lcs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  lcs_in_t   in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output lcs_out_t  out_data
);
  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_GCD   = 14'b00000000000010,
    S_MR    = 14'b00000000000100,
    S_BG    = 14'b00000000001000,
    S_AG    = 14'b00000000010000,
    S_AR    = 14'b00000000100000,
    S_BR    = 14'b00000001000000,
    S_INV   = 14'b00000010000000,
    S_RMUL  = 14'b00000100000000,
    S_RSUB  = 14'b00001000000000,
    S_X0    = 14'b00010000000000,
    S_EMIT  = 14'b00100000000000,
    S_WAIT  = 14'b01000000000000,
    S_FETCH = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic        busy_div_r, busy_div_nxt;  // a Euclid-step division is in flight
  logic [30:0] a_r, b_r, m_r, g_r, mr_r, br_r, x_r, r0_r, r1_r, t0_r, t1_r;
  logic [30:0] a_nxt, b_nxt, m_nxt, g_nxt, mr_nxt, br_nxt, x_nxt;
  logic [30:0] r0_nxt, r1_nxt, t0_nxt, t1_nxt;
  logic [QC_W-1:0] qcnt_r, qcnt_nxt, k_r, k_nxt;
  logic [6:0]  j_r, j_nxt;
  logic [6:0]  n_r, n_nxt;
  logic        trunc_r, trunc_nxt;
  logic [30:0] qd_r;
  logic [30:0] qstore [QUOT_DEPTH];
  logic        qwe;
  logic [30:0] qwdata;
  logic        ov_r, ov_nxt;
  lcs_out_t    od_r, od_nxt;
  lcs_div_req_t dreq;
  lcs_div_rsp_t drsp;

  lcs_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_stall  = (state_r != S_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    state_nxt = state_r;
    busy_div_nxt = busy_div_r;
    a_nxt = a_r; b_nxt = b_r; m_nxt = m_r; g_nxt = g_r; mr_nxt = mr_r;
    br_nxt = br_r; x_nxt = x_r; r0_nxt = r0_r; r1_nxt = r1_r;
    t0_nxt = t0_r; t1_nxt = t1_r; qcnt_nxt = qcnt_r; k_nxt = k_r;
    j_nxt = j_r; n_nxt = n_r; trunc_nxt = trunc_r;
    ov_nxt = ov_r && out_stall;
    od_nxt = od_r;
    dreq = '0;
    qwe = 1'b0;
    qwdata = drsp.quot[30:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          a_nxt = in_data.coef_a; b_nxt = in_data.rhs_b; m_nxt = in_data.modulus;
          if (in_data.modulus == 31'd0) begin
            od_nxt = '0;
            od_nxt.last = 1'b1;
            ov_nxt = 1'b1;
          end else begin
            r0_nxt = in_data.modulus;
            r1_nxt = in_data.coef_a;
            state_nxt = S_GCD;
          end
        end
      end
      S_GCD: begin
        if (r1_r == 31'd0) begin
          g_nxt = r0_r;
          dreq = '{1'b1, {31'd0, m_r}, r0_r};
          state_nxt = S_MR;
        end else if (!busy_div_r) begin
          dreq = '{1'b1, {31'd0, r0_r}, r1_r};
          busy_div_nxt = 1'b1;
        end else if (drsp.done) begin
          busy_div_nxt = 1'b0;
          r0_nxt = r1_r;
          r1_nxt = drsp.rem;
        end
      end
      S_MR: if (drsp.done) begin
        mr_nxt = drsp.quot[30:0];
        dreq = '{1'b1, {31'd0, b_r}, g_r};
        state_nxt = S_BG;
      end
      S_BG: if (drsp.done) begin
        if (drsp.rem != 31'd0) begin
          od_nxt = '0;
          od_nxt.step = mr_r;
          od_nxt.sol_count = g_r;
          od_nxt.last = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = S_WAIT;
        end else begin
          br_nxt = drsp.quot[30:0];
          dreq = '{1'b1, {31'd0, a_r}, g_r};
          state_nxt = S_AG;
        end
      end
      S_AG: if (drsp.done) begin
        dreq = '{1'b1, drsp.quot, mr_r};
        state_nxt = S_AR;
      end
      S_AR: if (drsp.done) begin
        r0_nxt = mr_r;
        r1_nxt = drsp.rem;
        dreq = '{1'b1, {31'd0, br_r}, mr_r};
        state_nxt = S_BR;
      end
      S_BR: if (drsp.done) begin
        br_nxt = drsp.rem;
        qcnt_nxt = '0;
        busy_div_nxt = 1'b0;
        state_nxt = S_INV;
      end
      S_INV: begin
        if (r1_r == 31'd0) begin
          t0_nxt = 31'd0;
          t1_nxt = (mr_r == 31'd1) ? 31'd0 : 31'd1;
          k_nxt = '0;
          state_nxt = (qcnt_r == '0) ? S_X0 : S_FETCH;
          if (qcnt_r == '0) dreq = '{1'b1, 62'd0, mr_r};
        end else if (!busy_div_r) begin
          dreq = '{1'b1, {31'd0, r0_r}, r1_r};
          busy_div_nxt = 1'b1;
        end else if (drsp.done) begin
          busy_div_nxt = 1'b0;
          if (qcnt_r < QC_W'(QUOT_DEPTH)) begin
            qwe = 1'b1;
            qcnt_nxt = qcnt_r + 1'b1;
          end
          r0_nxt = r1_r;
          r1_nxt = drsp.rem;
        end
      end
      S_FETCH: state_nxt = S_RMUL;  // store read data lands in qd_r
      S_RMUL: begin
        dreq = '{1'b1, 62'(qd_r * t1_r), mr_r};
        state_nxt = S_RSUB;
      end
      S_RSUB: if (drsp.done) begin
        t0_nxt = t1_r;
        t1_nxt = (t0_r >= drsp.rem) ? t0_r - drsp.rem : 31'(t0_r + mr_r - drsp.rem);
        k_nxt = k_r + 1'b1;
        if (k_r + 1'b1 == qcnt_r) begin
          state_nxt = S_X0;
          dreq = '{1'b1, 62'(t1_r * br_r), mr_r};
        end else begin
          state_nxt = S_FETCH;
        end
      end
      S_X0: if (drsp.done) begin
        x_nxt = drsp.rem;
        trunc_nxt = g_r > 31'(MAX_SOLUTIONS);
        n_nxt = (g_r > 31'(MAX_SOLUTIONS)) ? 7'(MAX_SOLUTIONS) : g_r[6:0];
        j_nxt = '0;
        state_nxt = S_EMIT;
      end
      S_EMIT: if (!ov_r || !out_stall) begin
        od_nxt.solvable = 1'b1;
        od_nxt.solution = x_r;
        od_nxt.sol_index = j_r[5:0];
        od_nxt.step = mr_r;
        od_nxt.sol_count = g_r;
        od_nxt.truncated = trunc_r;
        od_nxt.last = (j_r + 7'd1 == n_r);
        ov_nxt = 1'b1;
        x_nxt = x_r + mr_r;
        j_nxt = j_r + 7'd1;
        if (j_r + 7'd1 == n_r) state_nxt = S_WAIT;
      end
      S_WAIT: if (!ov_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (qwe) qstore[qcnt_r[QA_W-1:0]] <= qwdata;
    qd_r <= qstore[k_r[QA_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_div_r <= 1'b0;
      ov_r <= 1'b0;
      qcnt_r <= '0;
      k_r <= '0;
      j_r <= '0;
      r0_r <= '0; r1_r <= '0; t0_r <= '0; t1_r <= '0;
    end else begin
      state_r <= state_nxt;
      busy_div_r <= busy_div_nxt;
      ov_r <= ov_nxt;
      qcnt_r <= qcnt_nxt;
      k_r <= k_nxt;
      j_r <= j_nxt;
      r0_r <= r0_nxt; r1_r <= r1_nxt; t0_r <= t0_nxt; t1_r <= t1_nxt;
    end
    a_r <= a_nxt; b_r <= b_nxt; m_r <= m_nxt; g_r <= g_nxt; mr_r <= mr_nxt;
    br_r <= br_nxt; x_r <= x_nxt; n_r <= n_nxt; trunc_r <= trunc_nxt;
    od_r <= od_nxt;
  end

  `ASSERT_IMPL(a_stall_hold, clk, rst_n, out_valid && out_stall, ##1 $stable(out_data))
  `ASSERT_IMPL(a_busy_no_accept, clk, rst_n, state_r != S_IDLE, in_stall)
  `ASSERT_IMPL(a_emit_in_range, clk, rst_n, out_valid && out_data.solvable,
               out_data.solution < m_r)
endmodule
`default_nettype wire

### tb/testbench.sv
// Testbench for linear_congruence_solver: random and directed congruences a*x = b (mod m),
// checked result by result against a behavioral solver. Depends on lcs_pkg and the RTL.
`timescale 1ns / 1ps
module testbench;
  import lcs_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  lcs_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  lcs_out_t out_data;

  lcs_in_t  pending_items[$];
  lcs_out_t expected_solutions[$];
  int       error_count = 0;
  int       idle_cycles = 0;
  bit       stim_done = 0;
  bit       no_gaps = 0;
  bit       hold_send = 0;

  linear_congruence_solver dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [30:0] gcd_of(logic [30:0] x, logic [30:0] y);
    logic [30:0] r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  // Inverse of a mod n (gcd 1, a < n) by extended Euclid with coefficients kept mod n.
  function automatic logic [30:0] inverse_of(logic [30:0] a, logic [30:0] n);
    logic [30:0] r0, r1, q, r;
    logic [63:0] t0, t1, t2, prod;
    r0 = n;
    r1 = a;
    t0 = '0;
    t1 = 64'(1 % n);
    while (r1 != 0) begin
      q = r0 / r1;
      r = r0 - q * r1;
      r0 = r1;
      r1 = r;
      prod = (64'(q) * t1) % n;
      t2 = (t0 + n - prod) % n;
      t0 = t1;
      t1 = t2;
    end
    return t0[30:0];
  endfunction

  task automatic predict_solutions(lcs_in_t it);
    logic [30:0] g, mr, ar, br, inv, x0;
    int          n;
    lcs_out_t    res;
    res = '0;
    res.last = 1'b1;
    if (it.modulus == 0) begin
      expected_solutions.push_back(res);
      return;
    end
    g = gcd_of(it.coef_a, it.modulus);
    mr = it.modulus / g;
    res.step = mr;
    res.sol_count = g;
    if (it.rhs_b % g != 0) begin
      expected_solutions.push_back(res);
      return;
    end
    ar = (it.coef_a / g) % mr;
    br = (it.rhs_b / g) % mr;
    inv = inverse_of(ar, mr);
    x0 = 31'((64'(inv) * br) % mr);
    res.truncated = g > MAX_SOLUTIONS;
    n = res.truncated ? MAX_SOLUTIONS : int'(g);
    res.solvable = 1'b1;
    for (int j = 0; j < n; j++) begin
      res.solution = 31'(64'(x0) + 64'(j) * mr);
      res.sol_index = 6'(j);
      res.last = (j + 1 == n);
      expected_solutions.push_back(res);
    end
  endtask

  // Driver: a new item is presented only after the previous transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_solutions(in_data);
        void'(pending_items.pop_front());
      end
      if ((in_valid && !in_stall) || !in_valid) begin
        if (pending_items.size() > 0 && !hold_send &&
            (no_gaps || $urandom_range(99) >= 28)) begin
          in_valid <= 1'b1;
          in_data <= pending_items[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and random output stall.
  always @(posedge clk) begin
    lcs_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_solutions.size() == 0) begin
          $error("unexpected result %p", out_data);
          error_count++;
        end else begin
          want = expected_solutions.pop_front();
          if (out_data.solvable !== want.solvable) begin
            $error("solvable exp %0d got %0d", want.solvable, out_data.solvable);
            error_count++;
          end
          if (out_data.solution !== want.solution) begin
            $error("solution exp %0d got %0d", want.solution, out_data.solution);
            error_count++;
          end
          if (out_data.sol_index !== want.sol_index) begin
            $error("sol_index exp %0d got %0d", want.sol_index, out_data.sol_index);
            error_count++;
          end
          if (out_data.step !== want.step) begin
            $error("step exp %0d got %0d", want.step, out_data.step);
            error_count++;
          end
          if (out_data.sol_count !== want.sol_count) begin
            $error("sol_count exp %0d got %0d", want.sol_count, out_data.sol_count);
            error_count++;
          end
          if (out_data.truncated !== want.truncated) begin
            $error("truncated exp %0d got %0d", want.truncated, out_data.truncated);
            error_count++;
          end
          if (out_data.last !== want.last) begin
            $error("last exp %0d got %0d", want.last, out_data.last);
            error_count++;
          end
        end
      end
      out_stall <= !no_gaps && ($urandom_range(99) < 28);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic lcs_in_t make_item(logic [30:0] a, logic [30:0] b, logic [30:0] m);
    lcs_in_t it;
    it.coef_a = a;
    it.rhs_b = b;
    it.modulus = m;
    return it;
  endfunction

  function automatic lcs_in_t random_item();
    logic [30:0] g, a, m, b;
    int          kind;
    kind = $urandom_range(9);
    // Mostly a built from a small gcd so that several solutions come out.
    g = (kind < 6) ? 31'($urandom_range(1, 80)) : 31'(1);
    m = (kind == 9) ? 31'($urandom_range(1, 31'h7FFF_FFFF)) :
        31'(g * $urandom_range(1, 31'h7FFF_FFFF / g));
    a = 31'(g * $urandom_range(0, 31'h7FFF_FFFF / g));
    if (kind == 8) a = 31'($urandom());
    b = ($urandom_range(3) == 0) ? 31'($urandom() & 31'h7FFF_FFFF) :
        31'(g * $urandom_range(0, 31'h7FFF_FFFF / g));
    return make_item(a, b, m);
  endfunction

  initial begin
    pending_items.push_back(make_item(31'd0, 31'd0, 31'd1));
    pending_items.push_back(make_item(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
    pending_items.push_back(make_item(31'h7FFF_FFFF, 31'h7FFF_FFFE, 31'h7FFF_FFFE));
    pending_items.push_back(make_item(31'd3, 31'd5, 31'd7));
    pending_items.push_back(make_item(31'd4, 31'd3, 31'd6));
    pending_items.push_back(make_item(31'd4, 31'd2, 31'd6));
    pending_items.push_back(make_item(31'd0, 31'd5, 31'd10));
    pending_items.push_back(make_item(31'd0, 31'd20, 31'd10));
    pending_items.push_back(make_item(31'd30, 31'd10, 31'd10));
    pending_items.push_back(make_item(31'd128, 31'd256, 31'd1024));
    pending_items.push_back(make_item(31'd64, 31'd0, 31'd128));
    pending_items.push_back(make_item(31'd65, 31'd130, 31'd130));
    // Consecutive Fibonacci numbers give the longest Euclid run.
    pending_items.push_back(make_item(31'd1134903170, 31'd1, 31'd1836311903));
    pending_items.push_back(make_item(31'd1, 31'h7FFF_FFFF, 31'h4000_0000));
    pending_items.push_back(make_item(31'h5555_5555, 31'h2AAA_AAAA, 31'h7FFF_FFFF));
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() == 0 && !in_valid);
    hold_send = 1;
    wait (expected_solutions.size() == 0);
    hold_send = 0;
    for (int i = 0; i < 300; i++) pending_items.push_back(random_item());
    wait (pending_items.size() < 200);
    no_gaps = 1;
    wait (pending_items.size() < 150);
    no_gaps = 0;
    wait (pending_items.size() == 0 && !in_valid);
    wait (expected_solutions.size() == 0);
    repeat (8000) @(posedge clk);
    stim_done = 1;
  end

  initial begin
    wait (stim_done || idle_cycles >= WATCHDOG_LIMIT);
    if (stim_done && expected_solutions.size() == 0 && error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+hdl
hdl/lcs_pkg.sv
hdl/lcs_div.sv
hdl/linear_congruence_solver.sv
tb/testbench.sv
